// ----- hdl/asmv_pkg.sv -----
// Package: widths, constants and shared types of the millivolt ASCII formatter.
package asmv_pkg;

    // Sample and reference widths
    localparam int SAMPLE_BITS = 12;
    localparam int REF_W       = 14;
    localparam int MV_W        = 14;
    localparam int CHAR_W      = 8;

    localparam logic [SAMPLE_BITS-1:0] CODE_MAX  = {SAMPLE_BITS{1'b1}};
    localparam logic [REF_W-1:0]       REF_RESET = REF_W'(3300);
    localparam logic [MV_W-1:0]        MV_MAX    = MV_W'(9999);

    // Divide-by-(2^SAMPLE_BITS - 1) datapath widths
    localparam int PROD_W = SAMPLE_BITS + REF_W;
    localparam int FOLD_W = (REF_W > SAMPLE_BITS) ? REF_W + 1 : SAMPLE_BITS + 1;
    localparam int CARRY_W = FOLD_W - SAMPLE_BITS;
    localparam int QUOT_W = REF_W + 1;

    // Reciprocal constants for decimal digit extraction
    localparam int THOU_MUL = 8389;   // ~ 2^23 / 1000, exact for mv < 10000
    localparam int THOU_SH  = 23;
    localparam int THOU_PW  = MV_W + 14;
    localparam int HUND_MUL = 41;     // ~ 2^12 / 100, exact for rem < 1000
    localparam int HUND_SH  = 12;
    localparam int HUND_PW  = 16;
    localparam int TENS_MUL = 205;    // ~ 2^11 / 10, exact for rem < 100
    localparam int TENS_SH  = 11;
    localparam int TENS_PW  = 15;
    localparam int DIG_W    = 4;
    localparam int REM3_W   = 10;
    localparam int REM2_W   = 7;

    // ASCII codes
    localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;
    localparam logic [CHAR_W-1:0] CH_DOT  = 8'd46;
    localparam logic [CHAR_W-1:0] CH_CR   = 8'd13;
    localparam logic [CHAR_W-1:0] CH_LF   = 8'd10;

    // Event kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_CONV = 1'b1;

    // Scale pipeline depth
    localparam int NSTG = 7;

    // Conversion handed from the sequencer to the scaler
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] code;
        logic [REF_W-1:0]       ref_mv;
    } t_run;

    // Scaler pipeline payload
    typedef struct packed {
        logic [SAMPLE_BITS-1:0] code;
        logic [REF_W-1:0]       ref_mv;
        logic [PROD_W-1:0]      prod;
        logic [MV_W-1:0]        mv;
        logic [DIG_W-1:0]       thou;
        logic [REM3_W-1:0]      rem3;
        logic [DIG_W-1:0]       hund;
        logic [REM2_W-1:0]      rem2;
        logic [DIG_W-1:0]       tens;
    } t_scl;

    // Finished run handed to the serializer
    typedef struct packed {
        logic [MV_W-1:0]  mv;
        logic [DIG_W-1:0] thou;
        logic [DIG_W-1:0] hund;
        logic [DIG_W-1:0] tens;
    } t_dig;

    // Character position within a line
    typedef enum logic [2:0] {
        POS_THOU,
        POS_DOT,
        POS_HUND,
        POS_TENS,
        POS_CR,
        POS_LF
    } t_pos;

endpackage

// ----- hdl/asmv_if.sv -----
// Interfaces: event input, reference write and character output channels.
interface asmv_in_if;
    logic                              valid;
    logic                              ready;
    logic                              req_type;
    logic [asmv_pkg::SAMPLE_BITS-1:0]  sample_code;

    modport source (output valid, req_type, sample_code, input ready);
    modport sink   (input valid, req_type, sample_code, output ready);
endinterface

interface asmv_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [asmv_pkg::REF_W-1:0]  reference_mv;

    modport source (output valid, reference_mv, input ready);
    modport sink   (input valid, reference_mv, output ready);
endinterface

interface asmv_out_if;
    logic                         valid;
    logic                         ready;
    logic [asmv_pkg::CHAR_W-1:0]  ascii_char;
    logic                         last_char;
    logic [asmv_pkg::MV_W-1:0]    millivolts;

    modport source (output valid, ascii_char, last_char, millivolts, input ready);
    modport sink   (input valid, ascii_char, last_char, millivolts, output ready);
endinterface

// ----- hdl/adc_sample_to_ascii_millivolts.sv -----
// Top level: ADC code to millivolt ASCII line formatter.
//
// Channels: i_in carries events (req_type 0 = timer tick, 1 = conversion done
// with sample_code). i_cfg writes the full-scale reference in millivolts; it is
// always ready and should be written only while no run is in flight.
// o_out carries characters 'V' '.' 'H' 'T' CR LF, with last_char on the LF and
// millivolts (saturated at 9999) on all six.
// A tick moves the sequencer from idle to sampling; a pending conversion while
// sampling starts a run. Events that start no run produce nothing.
// The first character of a run is registered through the sequencer run register,
// the 7 scaler stages and the serializer register.
// Throughput: one event per cycle while i_in.ready is high; one character per
// cycle on the output while o_out.ready is high, and runs can follow back to back.
// When o_out stalls the serializer holds its character, the scaler pipeline
// fills, and i_in.ready drops once the sequencer's run register is blocked.
// Reset (synchronous, active low): idle, no pending flags, held code 0,
// reference 3300 mV, pipeline and serializer empty.
module adc_sample_to_ascii_millivolts (
    input  logic        i_clk,
    input  logic        i_rst_n,
    asmv_in_if.sink     i_in,
    asmv_cfg_if.sink    i_cfg,
    asmv_out_if.source  o_out
);

    logic            w_run_vld;
    logic            w_run_rdy;
    asmv_pkg::t_run  w_run;
    logic            w_dig_vld;
    logic            w_dig_rdy;
    asmv_pkg::t_dig  w_dig;

    asmv_seq u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_cfg     (i_cfg),
        .o_run_vld (w_run_vld),
        .i_run_rdy (w_run_rdy),
        .o_run     (w_run)
    );

    asmv_scale u_scale (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_run_vld (w_run_vld),
        .o_run_rdy (w_run_rdy),
        .i_run     (w_run),
        .o_dig_vld (w_dig_vld),
        .i_dig_rdy (w_dig_rdy),
        .o_dig     (w_dig)
    );

    asmv_ser u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_dig_vld (w_dig_vld),
        .o_dig_rdy (w_dig_rdy),
        .i_dig     (w_dig),
        .o_out     (o_out)
    );

    // Last marker rides exactly on the line feed
    a_last_on_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last_char == (o_out.ascii_char == asmv_pkg::CH_LF)))
        else $error("last_char not aligned with line feed");

    // Within a run, the next character follows at once with the same value
    a_run_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && !o_out.last_char)
            |=> (o_out.valid && $stable(o_out.millivolts)))
        else $error("run broken or millivolts changed mid-line");

    // Line done with no finished run waiting leaves the output empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last_char && !w_dig_vld) |=> !o_out.valid)
        else $error("character emitted without a run");

    // Scaled value never exceeds four digits
    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dig_vld |-> (w_dig.mv <= asmv_pkg::MV_MAX && w_dig.thou <= 4'd9))
        else $error("scaled value out of range");

endmodule

// ----- hdl/asmv_seq.sv -----
// Event sequencer: pending flags, idle/sampling phase, held code and reference register.
module asmv_seq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    asmv_in_if.sink               i_in,
    asmv_cfg_if.sink              i_cfg,
    output logic                  o_run_vld,
    input  logic                  i_run_rdy,
    output asmv_pkg::t_run        o_run
);

    logic                             r_phase, n_phase;
    logic                             r_tick, n_tick;
    logic                             r_conv, n_conv;
    logic [asmv_pkg::SAMPLE_BITS-1:0] r_code, n_code;
    logic [asmv_pkg::REF_W-1:0]       r_ref;
    logic                             r_run_vld;
    asmv_pkg::t_run                   r_run;
    logic                             w_acc;
    logic                             w_fire;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !r_run_vld || i_run_rdy;
    assign w_acc       = i_in.valid && i_in.ready;

    // Apply one event, then the phase transitions in order
    always_comb begin
        n_tick  = r_tick;
        n_conv  = r_conv;
        n_code  = r_code;
        n_phase = r_phase;
        w_fire  = 1'b0;
        if (w_acc) begin
            if (i_in.req_type == asmv_pkg::REQ_TICK) begin
                n_tick = 1'b1;
            end else begin
                n_conv = 1'b1;
                n_code = i_in.sample_code;
            end
            if (!n_phase && n_tick) begin
                n_tick  = 1'b0;
                n_phase = 1'b1;
            end
            if (n_phase && n_conv) begin
                w_fire  = 1'b1;
                n_conv  = 1'b0;
                n_phase = 1'b0;
                if (n_tick) begin
                    n_tick  = 1'b0;
                    n_phase = 1'b1;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= 1'b0;
            r_tick    <= 1'b0;
            r_conv    <= 1'b0;
            r_code    <= '0;
            r_ref     <= asmv_pkg::REF_RESET;
            r_run_vld <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_conv  <= n_conv;
            r_code  <= n_code;
            if (i_cfg.valid && i_cfg.ready) begin
                r_ref <= i_cfg.reference_mv;
            end
            if (i_in.ready) begin
                r_run_vld <= w_fire;
            end
        end
    end

    // Run payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_run.code   <= n_code;
            r_run.ref_mv <= r_ref;
        end
    end

    assign o_run_vld = r_run_vld;
    assign o_run     = r_run;

endmodule

// ----- hdl/asmv_scale.sv -----
// Scaler pipeline: code times reference over full scale, saturation, decimal digits.
module asmv_scale (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_run_vld,
    output logic                  o_run_rdy,
    input  asmv_pkg::t_run        i_run,
    output logic                  o_dig_vld,
    input  logic                  i_dig_rdy,
    output asmv_pkg::t_dig        o_dig
);

    asmv_pkg::t_scl                 r_stg [asmv_pkg::NSTG];
    asmv_pkg::t_scl                 n_stg [asmv_pkg::NSTG];
    logic [asmv_pkg::NSTG-1:0]      r_vld;
    logic [asmv_pkg::NSTG-1:0]      w_en;

    // Fold-based divide by 2^SAMPLE_BITS - 1
    logic [asmv_pkg::REF_W-1:0]       w_hi;
    logic [asmv_pkg::SAMPLE_BITS-1:0] w_lo;
    logic [asmv_pkg::FOLD_W-1:0]      w_fold;
    logic [asmv_pkg::CARRY_W-1:0]     w_carry;
    logic [asmv_pkg::SAMPLE_BITS:0]   w_fix;
    logic [asmv_pkg::QUOT_W-1:0]      w_quot;
    logic [asmv_pkg::THOU_PW-1:0]     w_thou_p;
    logic [asmv_pkg::MV_W-1:0]        w_rem3;
    logic [asmv_pkg::HUND_PW-1:0]     w_hund_p;
    logic [asmv_pkg::REM3_W-1:0]      w_rem2;
    logic [asmv_pkg::TENS_PW-1:0]     w_tens_p;

    // Stall chain, last stage first
    always_comb begin
        w_en[asmv_pkg::NSTG-1] = !r_vld[asmv_pkg::NSTG-1] || i_dig_rdy;
        for (int k = asmv_pkg::NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_run_rdy = w_en[0];

    // Per-stage arithmetic
    always_comb begin
        // stage 0: product
        n_stg[0]        = '0;
        n_stg[0].code   = i_run.code;
        n_stg[0].ref_mv = i_run.ref_mv;
        n_stg[0].prod   = asmv_pkg::PROD_W'(i_run.code) * asmv_pkg::PROD_W'(i_run.ref_mv);

        // stage 1: divide and saturate
        w_hi    = r_stg[0].prod[asmv_pkg::PROD_W-1:asmv_pkg::SAMPLE_BITS];
        w_lo    = r_stg[0].prod[asmv_pkg::SAMPLE_BITS-1:0];
        w_fold  = asmv_pkg::FOLD_W'(w_hi) + asmv_pkg::FOLD_W'(w_lo);
        w_carry = w_fold[asmv_pkg::FOLD_W-1:asmv_pkg::SAMPLE_BITS];
        w_fix   = (asmv_pkg::SAMPLE_BITS+1)'(w_carry)
                + (asmv_pkg::SAMPLE_BITS+1)'(w_fold[asmv_pkg::SAMPLE_BITS-1:0]);
        w_quot  = asmv_pkg::QUOT_W'(w_hi) + asmv_pkg::QUOT_W'(w_carry)
                + asmv_pkg::QUOT_W'(w_fix >= (asmv_pkg::SAMPLE_BITS+1)'(asmv_pkg::CODE_MAX));
        n_stg[1] = r_stg[0];
        n_stg[1].mv = (w_quot > asmv_pkg::QUOT_W'(asmv_pkg::MV_MAX)) ?
                      asmv_pkg::MV_MAX : w_quot[asmv_pkg::MV_W-1:0];

        // stage 2: thousands
        w_thou_p = asmv_pkg::THOU_PW'(r_stg[1].mv) * asmv_pkg::THOU_PW'(asmv_pkg::THOU_MUL);
        n_stg[2] = r_stg[1];
        n_stg[2].thou = w_thou_p[asmv_pkg::THOU_SH+asmv_pkg::DIG_W-1:asmv_pkg::THOU_SH];

        // stage 3: remainder below a thousand
        w_rem3 = r_stg[2].mv - asmv_pkg::MV_W'(r_stg[2].thou) * asmv_pkg::MV_W'(1000);
        n_stg[3] = r_stg[2];
        n_stg[3].rem3 = w_rem3[asmv_pkg::REM3_W-1:0];

        // stage 4: hundreds
        w_hund_p = asmv_pkg::HUND_PW'(r_stg[3].rem3) * asmv_pkg::HUND_PW'(asmv_pkg::HUND_MUL);
        n_stg[4] = r_stg[3];
        n_stg[4].hund = w_hund_p[asmv_pkg::HUND_SH+asmv_pkg::DIG_W-1:asmv_pkg::HUND_SH];

        // stage 5: remainder below a hundred
        w_rem2 = r_stg[4].rem3 - asmv_pkg::REM3_W'(r_stg[4].hund) * asmv_pkg::REM3_W'(100);
        n_stg[5] = r_stg[4];
        n_stg[5].rem2 = w_rem2[asmv_pkg::REM2_W-1:0];

        // stage 6: tens
        w_tens_p = asmv_pkg::TENS_PW'(r_stg[5].rem2) * asmv_pkg::TENS_PW'(asmv_pkg::TENS_MUL);
        n_stg[6] = r_stg[5];
        n_stg[6].tens = w_tens_p[asmv_pkg::TENS_SH+asmv_pkg::DIG_W-1:asmv_pkg::TENS_SH];
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_run_vld;
            end
            for (int k = 1; k < asmv_pkg::NSTG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < asmv_pkg::NSTG; k++) begin
            if (w_en[k]) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    assign o_dig_vld  = r_vld[asmv_pkg::NSTG-1];
    assign o_dig.mv   = r_stg[asmv_pkg::NSTG-1].mv;
    assign o_dig.thou = r_stg[asmv_pkg::NSTG-1].thou;
    assign o_dig.hund = r_stg[asmv_pkg::NSTG-1].hund;
    assign o_dig.tens = r_stg[asmv_pkg::NSTG-1].tens;

endmodule

// ----- hdl/asmv_ser.sv -----
// Line serializer: six registered characters per run, last marker on the line feed.
module asmv_ser (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_dig_vld,
    output logic                  o_dig_rdy,
    input  asmv_pkg::t_dig        i_dig,
    asmv_out_if.source            o_out
);

    logic                          r_busy, n_busy;
    asmv_pkg::t_pos                r_pos, n_pos, w_pos_inc;
    asmv_pkg::t_dig                r_dig, n_dig;
    logic [asmv_pkg::CHAR_W-1:0]   r_char, n_char;
    logic                          r_last;
    logic                          w_fire;
    logic                          w_take;

    assign w_fire    = r_busy && o_out.ready;
    assign o_dig_rdy = !r_busy || (w_fire && r_pos == asmv_pkg::POS_LF);
    assign w_take    = i_dig_vld && o_dig_rdy;

    // Position step
    always_comb begin
        unique case (r_pos)
            asmv_pkg::POS_THOU: w_pos_inc = asmv_pkg::POS_DOT;
            asmv_pkg::POS_DOT:  w_pos_inc = asmv_pkg::POS_HUND;
            asmv_pkg::POS_HUND: w_pos_inc = asmv_pkg::POS_TENS;
            asmv_pkg::POS_TENS: w_pos_inc = asmv_pkg::POS_CR;
            asmv_pkg::POS_CR:   w_pos_inc = asmv_pkg::POS_LF;
            default:            w_pos_inc = asmv_pkg::POS_THOU;
        endcase
    end

    // Next run / position
    always_comb begin
        n_busy = r_busy;
        n_pos  = r_pos;
        if (w_take) begin
            n_busy = 1'b1;
            n_pos  = asmv_pkg::POS_THOU;
        end else if (w_fire) begin
            if (r_pos == asmv_pkg::POS_LF) begin
                n_busy = 1'b0;
            end else begin
                n_pos = w_pos_inc;
            end
        end
        n_dig = w_take ? i_dig : r_dig;
    end

    // Character decode
    always_comb begin
        unique case (n_pos)
            asmv_pkg::POS_THOU: n_char = asmv_pkg::CH_ZERO + asmv_pkg::CHAR_W'(n_dig.thou);
            asmv_pkg::POS_DOT:  n_char = asmv_pkg::CH_DOT;
            asmv_pkg::POS_HUND: n_char = asmv_pkg::CH_ZERO + asmv_pkg::CHAR_W'(n_dig.hund);
            asmv_pkg::POS_TENS: n_char = asmv_pkg::CH_ZERO + asmv_pkg::CHAR_W'(n_dig.tens);
            asmv_pkg::POS_CR:   n_char = asmv_pkg::CH_CR;
            default:            n_char = asmv_pkg::CH_LF;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= asmv_pkg::POS_THOU;
        end else begin
            r_busy <= n_busy;
            r_pos  <= n_pos;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        r_dig  <= n_dig;
        r_char <= n_char;
        r_last <= (n_pos == asmv_pkg::POS_LF);
    end

    assign o_out.valid      = r_busy;
    assign o_out.ascii_char = r_char;
    assign o_out.last_char  = r_last;
    assign o_out.millivolts = r_dig.mv;

endmodule
